// ===== rtl/core/rcsfp_pkg.sv =====
// Shared types, codes and constants of the RC servo frame parser.
// No dependencies; imported by every module of the block.
package rcsfp_pkg;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int SCALED_W   = 10;
    localparam int TIME_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    // Wide enough for the largest supported channel count
    localparam int CELL_IDX_W = 5;

    // Frame header
    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h20;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h40;

    // Per-mille scaling
    localparam logic [WORD_W-1:0]   SCALE_BASE = 16'd1000;
    localparam logic [WORD_W-1:0]   SCALE_TOP  = 16'd2000;
    localparam logic [SCALED_W-1:0] SCALE_SPAN = 10'd1000;

    localparam logic [TIME_W-1:0] IDLE_MAX = 16'hFFFF;

    // Configuration register reset values
    localparam logic [TIME_W-1:0] DISCONNECT_RESET = 16'd100;
    localparam logic [TIME_W-1:0] RESYNC_RESET     = 16'd10;

    // Item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISCONNECT = 1'b0,
        REG_RESYNC     = 1'b1
    } cfg_reg_t;

    // One completed channel word heading for the cell row
    typedef struct packed {
        logic                  valid;
        logic [CELL_IDX_W-1:0] idx;
        logic [WORD_W-1:0]     data;
    } word_wr_t;

    // Events raised by the framer for one accepted item
    typedef struct packed {
        word_wr_t word;
        logic     frame_done;
        logic     link_lost;
    } frm_evt_t;

    // Raw minus base, clamped to 0..span
    function automatic logic [SCALED_W-1:0] scale_raw(input logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] diff;
        diff = raw - SCALE_BASE;
        if (raw <= SCALE_BASE) begin
            return '0;
        end else if (raw >= SCALE_TOP) begin
            return SCALE_SPAN;
        end else begin
            return diff[SCALED_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/rcsfp_cell.sv =====
// One channel cell of the word row: holds one channel word.
// Depends on rcsfp_pkg for the word write type.
module rcsfp_cell
    import rcsfp_pkg::*;
#(
    parameter int CELL_ID = 0
) (
    input  logic              aclk,
    input  word_wr_t          word_wr,
    input  logic              shift_en,
    input  logic [WORD_W-1:0] nbr_word,
    output logic [WORD_W-1:0] word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (shift_en) begin
            word_next = nbr_word;
        end else if (word_wr.valid && (word_wr.idx == CELL_IDX_W'(CELL_ID))) begin
            word_next = word_wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== rtl/core/rcsfp_framer.sv =====
// Header hunt, byte gathering, idle timing and link state of the parser.
// Depends on rcsfp_pkg; owns the two configuration registers.
module rcsfp_framer
    import rcsfp_pkg::*;
#(
    parameter int FRAME_BYTES   = 32,
    parameter int CHANNEL_COUNT = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  accept,
    input  logic                  op,
    input  logic [BYTE_W-1:0]     data_byte,
    output frm_evt_t              evt
);

    localparam int POS_W = $clog2(FRAME_BYTES + 1);
    localparam int CMP_W = 8;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_SECOND = 3'b010,
        PH_BODY   = 3'b100
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BYTE_W-1:0]   low_reg, low_next;
    logic                link_reg, link_next;
    logic [TIME_W-1:0]   idle_reg, idle_next;
    logic [TIME_W-1:0]   disc_reg, disc_next;
    logic [TIME_W-1:0]   resync_reg, resync_next;

    logic [POS_W-1:0]    off;
    logic [POS_W-1:0]    pos_inc;
    logic [CMP_W-1:0]    ch;
    logic [TIME_W-1:0]   idle_inc;

    assign off      = pos_reg - POS_W'(2);
    assign pos_inc  = pos_reg + POS_W'(1);
    assign ch       = CMP_W'(off >> 1);
    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + TIME_W'(1);

    always_comb begin
        disc_next   = disc_reg;
        resync_next = resync_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DISCONNECT: disc_next   = cfg_wr_data;
                REG_RESYNC:     resync_next = cfg_wr_data;
                default:        ;
            endcase
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        low_next   = low_reg;
        link_next  = link_reg;
        idle_next  = idle_reg;
        evt        = '0;
        evt.word.data = {data_byte, low_reg};
        evt.word.idx  = CELL_IDX_W'(ch);

        if (accept && (op == OP_TICK)) begin
            idle_next = idle_inc;
            // abandon a partial frame
            if (idle_inc > resync_reg) begin
                phase_next = PH_HUNT;
                pos_next   = '0;
            end
            // drop the link once
            if ((idle_inc > disc_reg) && link_reg) begin
                link_next     = 1'b0;
                evt.link_lost = 1'b1;
            end
        end else if (accept) begin
            idle_next = '0;
            unique case (phase_reg)
                PH_SECOND: begin
                    if (data_byte == HDR_SECOND) begin
                        phase_next = PH_BODY;
                        pos_next   = POS_W'(2);
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    if (!off[0]) begin
                        low_next = data_byte;
                    end else if (ch < CMP_W'(CHANNEL_COUNT)) begin
                        evt.word.valid = 1'b1;
                    end
                    if (pos_inc == POS_W'(FRAME_BYTES)) begin
                        link_next      = 1'b1;
                        phase_next     = PH_HUNT;
                        pos_next       = '0;
                        evt.frame_done = 1'b1;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (data_byte == HDR_FIRST) begin
                        phase_next = PH_SECOND;
                        pos_next   = POS_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            pos_reg    <= '0;
            low_reg    <= '0;
            link_reg   <= 1'b0;
            idle_reg   <= '0;
            disc_reg   <= DISCONNECT_RESET;
            resync_reg <= RESYNC_RESET;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            low_reg    <= low_next;
            link_reg   <= link_next;
            idle_reg   <= idle_next;
            disc_reg   <= disc_next;
            resync_reg <= resync_next;
        end
    end

endmodule

// ===== rtl/core/rc_servo_frame_parser.sv =====
// Top level of the RC servo frame parser: framer, channel cell row, result register.
// Depends on rcsfp_pkg, rcsfp_framer and rcsfp_cell.
//
//  channel | ports                         | direction | transfer when
//  --------+-------------------------------+-----------+-------------------------
//  input   | s_valid s_ready s_op s_data.. | in        | s_valid && s_ready
//  result  | m_valid m_ready m_kind ...    | out       | m_valid && m_ready
//  config  | cfg_wr_en cfg_index cfg_wr_d  | in        | cfg_wr_en
//
//  Cycles: one byte or tick is taken per cycle while s_ready is high.
//  A completed frame unloads CHANNEL_COUNT results, one per cycle at best,
//  by rotating the cell row into the result register; s_ready stays low
//  until the last of them is loaded.
//  s_ready also stays low while a result sits unread in the result register.
//  Reset (aresetn, synchronous, active low) clears framing, link state, idle
//  time and restores the timeout registers; channel words are not cleared.
module rc_servo_frame_parser
    import rcsfp_pkg::*;
#(
    parameter int FRAME_BYTES   = 32,
    parameter int CHANNEL_COUNT = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [BYTE_W-1:0]     s_data_byte,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic [((CHANNEL_COUNT > 16) ? 5 : 4)-1:0] m_channel_index,
    output logic [WORD_W-1:0]     m_raw_value,
    output logic [SCALED_W-1:0]   m_scaled_value,
    output logic                  m_link_up,
    output logic                  m_last
);

    localparam int IDX_W = (CHANNEL_COUNT > 16) ? 5 : 4;

    frm_evt_t             evt;
    logic                 accept;
    logic                 load;

    logic                 busy_reg, busy_next;
    logic [CELL_IDX_W-1:0] cnt_reg, cnt_next;
    logic                 cnt_last;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_kind_reg, m_kind_next;
    logic [IDX_W-1:0]     m_idx_reg, m_idx_next;
    logic [WORD_W-1:0]    m_raw_reg, m_raw_next;
    logic [SCALED_W-1:0]  m_scaled_reg, m_scaled_next;
    logic                 m_up_reg, m_up_next;
    logic                 m_last_reg, m_last_next;

    logic [WORD_W-1:0]    cell_word [CHANNEL_COUNT];

    // Take an item only with no run in progress and room in the result register
    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    rcsfp_framer #(
        .FRAME_BYTES   (FRAME_BYTES),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .op          (s_op),
        .data_byte   (s_data_byte),
        .evt         (evt)
    );

    // Advance the row by one cell per loaded result; after a full run it is back in place
    assign load     = busy_reg && (!m_valid_reg || m_ready);
    assign cnt_last = (cnt_reg == CELL_IDX_W'(CHANNEL_COUNT - 1));

    for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_cell
        localparam int NEXT = (i + 1) % CHANNEL_COUNT;
        rcsfp_cell #(
            .CELL_ID (i)
        ) u_cell (
            .aclk     (aclk),
            .word_wr  (evt.word),
            .shift_en (load),
            .nbr_word (cell_word[NEXT]),
            .word     (cell_word[i])
        );
    end

    always_comb begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        m_kind_next   = m_kind_reg;
        m_idx_next    = m_idx_reg;
        m_raw_next    = m_raw_reg;
        m_scaled_next = m_scaled_reg;
        m_up_next     = m_up_reg;
        m_last_next   = m_last_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (load) begin
            // channel result straight from the head cell
            m_valid_next  = 1'b1;
            m_kind_next   = KIND_CHANNEL;
            m_idx_next    = IDX_W'(cnt_reg);
            m_raw_next    = cell_word[0];
            m_scaled_next = scale_raw(cell_word[0]);
            m_up_next     = 1'b1;
            m_last_next   = cnt_last;
            cnt_next      = cnt_reg + CELL_IDX_W'(1);
            if (cnt_last) begin
                busy_next = 1'b0;
            end
        end else if (evt.link_lost) begin
            // single status result
            m_valid_next  = 1'b1;
            m_kind_next   = KIND_STATUS;
            m_idx_next    = '0;
            m_raw_next    = '0;
            m_scaled_next = '0;
            m_up_next     = 1'b0;
            m_last_next   = 1'b1;
        end

        if (evt.frame_done) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold payload; no reset needed
    always_ff @(posedge aclk) begin
        m_kind_reg   <= m_kind_next;
        m_idx_reg    <= m_idx_next;
        m_raw_reg    <= m_raw_next;
        m_scaled_reg <= m_scaled_next;
        m_up_reg     <= m_up_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_channel_index = m_idx_reg;
    assign m_raw_value     = m_raw_reg;
    assign m_scaled_value  = m_scaled_reg;
    assign m_link_up       = m_up_reg;
    assign m_last          = m_last_reg;

endmodule

// ===== rtl/core/rcsfp_checker.sv =====
// Port-level checks on the result channel of the RC servo frame parser.
// Depends on rcsfp_pkg; bound to rc_servo_frame_parser below.
module rcsfp_checker
    import rcsfp_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_kind,
    input logic [IDX_W-1:0]    m_channel_index,
    input logic [WORD_W-1:0]   m_raw_value,
    input logic [SCALED_W-1:0] m_scaled_value,
    input logic                m_link_up,
    input logic                m_last
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_raw_value) && $stable(m_kind)
            && $stable(m_channel_index) && $stable(m_last))
        else $error("result changed while stalled");

    // status result is a lone, link-down, zeroed item
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_STATUS) |-> m_last && !m_link_up
            && (m_channel_index == '0) && (m_raw_value == '0))
        else $error("malformed status result");

    // channel results carry link up and a scaled value in range
    a_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_CHANNEL) |-> m_link_up && (m_scaled_value <= 10'd1000))
        else $error("malformed channel result");

    // a run continues with the next channel at once
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_kind == KIND_CHANNEL) && !m_last
            |=> m_valid && (m_kind == KIND_CHANNEL)
                && (m_channel_index == $past(m_channel_index) + IDX_W'(1)))
        else $error("channel run broken");

endmodule

bind rc_servo_frame_parser rcsfp_checker #(
    .IDX_W (IDX_W)
) u_rcsfp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_kind          (m_kind),
    .m_channel_index (m_channel_index),
    .m_raw_value     (m_raw_value),
    .m_scaled_value  (m_scaled_value),
    .m_link_up       (m_link_up),
    .m_last          (m_last)
);

// ===== sim/rcsfp_test_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard of the RC servo frame parser test: an untimed model of the framer
// that turns accepted bytes and ticks into awaited results and checks them.
// Depends on rcsfp_pkg.
package rcsfp_test_pkg;
    import rcsfp_pkg::*;

    localparam int FRAME_LEN = 32;
    localparam int CHANNELS  = 14;

    typedef enum logic [1:0] {
        SYNC_HUNT,
        SYNC_SECOND,
        SYNC_BODY
    } sync_state_t;

    typedef struct packed {
        logic                kind;
        logic [3:0]          channel;
        logic [WORD_W-1:0]   raw;
        logic [SCALED_W-1:0] per_mille;
        logic                link_up;
        logic                last;
    } servo_result_t;

    class servo_frame_scoreboard;
        logic [TIME_W-1:0] link_timeout;
        logic [TIME_W-1:0] resync_timeout;
        sync_state_t       sync;
        logic [5:0]        pos;
        logic [BYTE_W-1:0] low_byte;
        logic [WORD_W-1:0] words [CHANNELS];
        logic              link;
        logic [TIME_W-1:0] idle;
        servo_result_t     decoded_results[$];
        int                failures;

        function new();
            link_timeout   = DISCONNECT_RESET;
            resync_timeout = RESYNC_RESET;
            sync           = SYNC_HUNT;
            pos            = '0;
            low_byte       = '0;
            link           = 1'b0;
            idle           = '0;
            failures       = 0;
            foreach (words[i]) words[i] = '0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_DISCONNECT: link_timeout = value;
                REG_RESYNC:     resync_timeout = value;
                default: ;
            endcase
        endfunction

        function logic [SCALED_W-1:0] per_mille_of(logic [WORD_W-1:0] raw);
            int above;
            above = int'(raw) - int'(SCALE_BASE);
            if (above < 0) begin
                above = 0;
            end else if (above > int'(SCALE_SPAN)) begin
                above = int'(SCALE_SPAN);
            end
            return above[SCALED_W-1:0];
        endfunction

        // Advance the framer by one accepted transfer and queue what it emits
        function void note_item(logic op, logic [BYTE_W-1:0] b);
            servo_result_t r;
            logic [5:0]    off;
            int            c;
            if (op == OP_TICK) begin
                if (idle != IDLE_MAX) idle = idle + 1'b1;
                if (idle > resync_timeout) begin
                    sync = SYNC_HUNT;
                    pos  = '0;
                end
                if (idle > link_timeout && link) begin
                    link = 1'b0;
                    r = '0;
                    r.kind = KIND_STATUS;
                    r.last = 1'b1;
                    decoded_results.push_back(r);
                end
                return;
            end
            idle = '0;
            case (sync)
                SYNC_SECOND: begin
                    if (b == HDR_SECOND) begin
                        sync = SYNC_BODY;
                        pos  = 6'd2;
                    end else begin
                        sync = SYNC_HUNT;
                    end
                end
                SYNC_BODY: begin
                    off = pos - 6'd2;
                    if (!off[0]) begin
                        low_byte = b;
                    end else if (off[5:1] < CHANNELS) begin
                        words[off[5:1]] = {b, low_byte};
                    end
                    pos = pos + 1'b1;
                    if (pos == FRAME_LEN) begin
                        link = 1'b1;
                        sync = SYNC_HUNT;
                        pos  = '0;
                        for (c = 0; c < CHANNELS; c++) begin
                            r.kind      = KIND_CHANNEL;
                            r.channel   = c[3:0];
                            r.raw       = words[c];
                            r.per_mille = per_mille_of(words[c]);
                            r.link_up   = 1'b1;
                            r.last      = (c == CHANNELS - 1);
                            decoded_results.push_back(r);
                        end
                    end
                end
                default: begin
                    if (b == HDR_FIRST) begin
                        sync = SYNC_SECOND;
                        pos  = 6'd1;
                    end else begin
                        sync = SYNC_HUNT;
                    end
                end
            endcase
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(servo_result_t got);
            servo_result_t want;
            if (decoded_results.size() == 0) begin
                $error("result with none awaited: kind %0d channel %0d raw %0d",
                       got.kind, got.channel, got.raw);
                failures++;
                return;
            end
            want = decoded_results.pop_front();
            compare("kind", want.kind, got.kind);
            compare("channel_index", want.channel, got.channel);
            compare("raw_value", want.raw, got.raw);
            compare("scaled_value", want.per_mille, got.per_mille);
            compare("link_up", want.link_up, got.link_up);
            compare("last", want.last, got.last);
        endfunction

        function int pending();
            return decoded_results.size();
        endfunction

        function void report_leftovers();
            if (decoded_results.size() != 0) begin
                $error("%0d awaited results never arrived", decoded_results.size());
                failures++;
            end
        endfunction
    endclass

endpackage

// ===== sim/rc_servo_frame_parser_test.sv =====
`timescale 1ns / 100ps
// Top of the RC servo frame parser test: clock, reset, drivers for the byte/tick
// and result channels, the register port, and the stimulus phases.
// Depends on rcsfp_pkg, rcsfp_test_pkg and the rc_servo_frame_parser RTL.
module rc_servo_frame_parser_test;
    import rcsfp_pkg::*;
    import rcsfp_test_pkg::*;

    // Length of the deliberate receiver hold-off, in clock cycles
    localparam int RX_HOLD_CYCLES = 400;
    // Cycles to let the block settle before a register write and at the end
    localparam int SETTLE_CYCLES  = 20;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    cfg_reg_t              cfg_index   = REG_DISCONNECT;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_op        = OP_BYTE;
    logic [BYTE_W-1:0]     s_data_byte = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_kind;
    logic [3:0]            m_channel_index;
    logic [WORD_W-1:0]     m_raw_value;
    logic [SCALED_W-1:0]   m_scaled_value;
    logic                  m_link_up;
    logic                  m_last;

    // Idle percentages of sender and receiver, changed per phase
    int send_idle_pct = 25;
    int recv_idle_pct = 70;
    int items_sent    = 0;

    // Receiver hold-off: the stimulus toggles the request, the receiver counts
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;

    logic [WORD_W-1:0] frame_words [CHANNELS];

    servo_frame_scoreboard frames;

    always #10 aclk = ~aclk;

    rc_servo_frame_parser #(
        .FRAME_BYTES   (FRAME_LEN),
        .CHANNEL_COUNT (CHANNELS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_channel_index (m_channel_index),
        .m_raw_value     (m_raw_value),
        .m_scaled_value  (m_scaled_value),
        .m_link_up       (m_link_up),
        .m_last          (m_last)
    );

    // Receiver: drop ready at random, or hold it low for a long stretch on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= RX_HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Sample both channels on the pre-edge values; check results before noting
    // the input so that a result is always matched against older items
    always @(posedge aclk) begin : transfer_monitor
        servo_result_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.kind      = m_kind;
                seen.channel   = m_channel_index;
                seen.raw       = m_raw_value;
                seen.per_mille = m_scaled_value;
                seen.link_up   = m_link_up;
                seen.last      = m_last;
                frames.check_result(seen);
            end
            if (s_valid && s_ready) frames.note_item(s_op, s_data_byte);
        end
    end

    // Offer one item, idling first at random; return at the edge that takes it.
    // Valid is left high so the next item follows without a gap.
    task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(OP_TICK, BYTE_W'($urandom));
    endtask

    // Random bytes, biased towards the header codes to provoke false syncs
    task automatic send_noise(input int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                send_item(OP_BYTE, HDR_FIRST);
            end else if (pick < 40) begin
                send_item(OP_BYTE, HDR_SECOND);
            end else begin
                send_item(OP_BYTE, BYTE_W'($urandom));
            end
        end
    endtask

    // Mostly stick-like values around the scaled span, some extremes, some anything
    task automatic random_frame_words();
        foreach (frame_words[i]) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: frame_words[i] = WORD_W'($urandom_range(2100, 900));
                5: begin
                    case ($urandom_range(5))
                        0:       frame_words[i] = 16'd0;
                        1:       frame_words[i] = 16'd1000;
                        2:       frame_words[i] = 16'd1001;
                        3:       frame_words[i] = 16'd1999;
                        4:       frame_words[i] = 16'd2000;
                        default: frame_words[i] = 16'hFFFF;
                    endcase
                end
                default: frame_words[i] = WORD_W'($urandom);
            endcase
        end
    endtask

    // Send the header, frame_words low byte first and random checksum bytes;
    // stop after stop_at bytes, and now and then slip in a run of ticks
    task automatic send_frame(input int gap_max, input int stop_at);
        int                p;
        logic [BYTE_W-1:0] b;
        logic [WORD_W-1:0] w;
        for (p = 0; p < stop_at; p++) begin
            if (p == 0) begin
                b = HDR_FIRST;
            end else if (p == 1) begin
                b = HDR_SECOND;
            end else if (p < 2 + 2 * CHANNELS) begin
                w = frame_words[(p - 2) / 2];
                b = p[0] ? w[15:8] : w[7:0];
            end else begin
                b = BYTE_W'($urandom);
            end
            if (p > 0 && gap_max > 0 && $urandom_range(99) < 2) begin
                send_ticks($urandom_range(gap_max, 1));
            end
            send_item(OP_BYTE, b);
        end
    endtask

    // Mostly whole frames with random content; the rest broken frames, short tick
    // runs, idle runs long enough to drop the link, and stray bytes
    task automatic random_traffic(input int n, input int gap_max);
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < n) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                random_frame_words();
                send_frame(gap_max, FRAME_LEN);
            end else if (pick < 72) begin
                random_frame_words();
                send_frame(gap_max, $urandom_range(FRAME_LEN - 1, 2));
                // resync so the next frame lines up again
                if (frames.resync_timeout < 64) send_ticks(int'(frames.resync_timeout) + 1);
            end else if (pick < 82) begin
                send_ticks($urandom_range(3, 1));
            end else if (pick < 90) begin
                if (frames.link_timeout < 128) begin
                    send_ticks(int'(frames.link_timeout) + $urandom_range(2, 1));
                end else begin
                    send_ticks($urandom_range(40, 5));
                end
            end else begin
                send_noise($urandom_range(6, 1));
            end
        end
    endtask

    // Pause the sender until every awaited result is in, then let the block settle
    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both timeouts, disconnect first, then resync; call only while the block is idle
    task automatic write_timeouts(input logic [TIME_W-1:0] link_ms,
                                  input logic [TIME_W-1:0] resync_ms);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_DISCONNECT;
        cfg_wr_data <= link_ms;
        @(posedge aclk);
        cfg_index   <= REG_RESYNC;
        cfg_wr_data <= resync_ms;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        frames.set_reg(REG_DISCONNECT, link_ms);
        frames.set_reg(REG_RESYNC, resync_ms);
    endtask

    initial begin
        frames = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase one: reset timeouts, sender idles a little, receiver a lot.
        // Stray bytes and a tick while the link is still down
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_TICK, 8'hA5);
        // second header byte on its own
        send_item(OP_BYTE, HDR_SECOND);
        // repeated first header byte is not taken as the second
        send_item(OP_BYTE, HDR_FIRST);
        send_item(OP_BYTE, HDR_FIRST);
        // wrong second byte sends the framer back to hunting
        send_item(OP_BYTE, HDR_FIRST);
        send_item(OP_BYTE, 8'h41);
        // partial frame abandoned once idle time passes the resync timeout
        random_frame_words();
        send_frame(0, 5);
        send_ticks(int'(RESYNC_RESET) + 1);
        // clamp edges of the scaled value, both byte halves, full range
        frame_words = '{16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001, 16'd1500, 16'd1999,
                        16'd2000, 16'd2001, 16'h00FF, 16'hFF00, 16'h7FFF, 16'h8000,
                        16'hFFFF};
        send_frame(0, FRAME_LEN);
        // idle past the disconnect timeout: one status, then silence
        send_ticks(int'(DISCONNECT_RESET) + 1);
        send_item(OP_TICK, 8'h5A);
        random_traffic(90, 12);
        quiesce();

        // Phase two: both timeouts at zero, sender idles a lot, receiver a little
        send_idle_pct = 70;
        recv_idle_pct = 25;
        write_timeouts('0, '0);
        random_traffic(90, 2);
        quiesce();

        // Phase three: no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_timeouts(16'd30, 16'd3);
        random_traffic(80, 5);
        // Hold the receiver off while whole frames keep coming, so the block
        // fills up and stalls its input
        hold_toggle <= ~hold_toggle;
        repeat (3) begin
            random_frame_words();
            send_frame(0, FRAME_LEN);
        end

        quiesce();
        frames.report_leftovers();
        if (frames.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: reports FAILURE and stops if the test has not finished by then
    initial begin
        #16_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rcsfp_pkg.sv
rtl/core/rcsfp_cell.sv
rtl/core/rcsfp_framer.sv
rtl/core/rc_servo_frame_parser.sv
rtl/core/rcsfp_checker.sv
sim/rcsfp_test_pkg.sv
sim/rc_servo_frame_parser_test.sv
